// ===== design/ssi_pkg.sv =====
package ssi_pkg;

   localparam int DATA_W        = 32;
   localparam int ACTION_W      = 2;
   localparam int SET_DEPTH_DEF = 32;

   typedef logic [DATA_W-1:0]   data_type;
   typedef logic [ACTION_W-1:0] action_type;

   localparam action_type ACT_LOAD_A = 2'd0;
   localparam action_type ACT_LOAD_B = 2'd1;
   localparam action_type ACT_RUN    = 2'd2;

endpackage

// ===== design/ssi_store.sv =====
module ssi_store import ssi_pkg::*; #(
   parameter int  SET_DEPTH = SET_DEPTH_DEF,
   localparam int IDX_W     = $clog2(SET_DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [IDX_W-1:0] waddr,
   input  data_type         wdata,
   input  logic [IDX_W-1:0] raddr,
   output data_type         rdata
);

   data_type mem [SET_DEPTH];
   data_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/sorted_set_intersection_unit.sv =====
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_action, req_value
// rsp     | out       | rsp_valid / rsp_ready | rsp_common_value, rsp_is_last,
//         |           |                       | rsp_is_empty, rsp_overflowed
// a load transaction is taken in ST_IDLE and the block stays ready for the next one
// a run transaction bubble-sorts set A then set B through one comparator and one
// read port per store: a pass over n elements runs ST_SRT_RD0, ST_SRT_LD, ST_SRT_SCAN
// and ST_SRT_LAST, n - 1 passes per set; a merge step then runs ST_MRG_RD, ST_MRG_CMP
// and drops one element, or one from each set on a match
// reset clears counts, drop flag and control; the stores are not cleared
// a stalled rsp holds the merge until the output register frees up
module sorted_set_intersection_unit import ssi_pkg::*; #(
   parameter int  SET_DEPTH = SET_DEPTH_DEF,
   localparam int IDX_W     = $clog2(SET_DEPTH),
   localparam int CNT_W     = $clog2(SET_DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ACTION_W-1:0]      req_action,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_common_value,
   output logic                     rsp_is_last,
   output logic                     rsp_is_empty,
   output logic                     rsp_overflowed
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRT_START,
      ST_SRT_RD0,
      ST_SRT_LD,
      ST_SRT_SCAN,
      ST_SRT_LAST,
      ST_MRG_RD,
      ST_MRG_CMP,
      ST_FIN
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;
   logic             drop_ff, drop_in;
   logic             sel_b_ff, sel_b_in;
   logic [IDX_W-1:0] lim_ff, lim_in;
   logic [IDX_W-1:0] j_ff, j_in;
   data_type         hold_ff, hold_in;
   logic [CNT_W-1:0] ia_ff, ia_in;
   logic [CNT_W-1:0] ib_ff, ib_in;
   data_type         pend_ff, pend_in;
   logic             have_pend_ff, have_pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   data_type         rsp_value_ff, rsp_value_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic             out_free;
   logic             in_sort;
   logic             in_merge;
   logic             load_we_a, load_we_b;
   logic             sort_we;
   logic [IDX_W-1:0] sort_waddr;
   data_type         sort_wdata;
   logic [IDX_W-1:0] sort_raddr;
   logic [CNT_W-1:0] sort_n;

   logic             we_a, we_b;
   logic [IDX_W-1:0] waddr_a, waddr_b;
   data_type         wdata_a, wdata_b;
   logic [IDX_W-1:0] raddr_a, raddr_b;
   data_type         rdata_a, rdata_b, rdata_sel;

   data_type         cmp_x, cmp_y;
   logic             cmp_gt, cmp_eq;

   // shared comparator
   assign in_sort  = (state_ff == ST_SRT_START) || (state_ff == ST_SRT_RD0) ||
                     (state_ff == ST_SRT_LD) || (state_ff == ST_SRT_SCAN) ||
                     (state_ff == ST_SRT_LAST);
   assign in_merge = (state_ff == ST_MRG_RD) || (state_ff == ST_MRG_CMP);
   assign rdata_sel = sel_b_ff ? rdata_b : rdata_a;
   assign cmp_x  = in_merge ? rdata_a : hold_ff;
   assign cmp_y  = in_merge ? rdata_b : rdata_sel;
   assign cmp_gt = $signed(cmp_x) > $signed(cmp_y);
   assign cmp_eq = cmp_x == cmp_y;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign sort_n   = sel_b_ff ? count_b_ff : count_a_ff;

   // store port muxing
   assign we_a    = load_we_a || (sort_we && !sel_b_ff);
   assign we_b    = load_we_b || (sort_we && sel_b_ff);
   assign waddr_a = load_we_a ? count_a_ff[IDX_W-1:0] : sort_waddr;
   assign waddr_b = load_we_b ? count_b_ff[IDX_W-1:0] : sort_waddr;
   assign wdata_a = load_we_a ? data_type'(req_value) : sort_wdata;
   assign wdata_b = load_we_b ? data_type'(req_value) : sort_wdata;
   assign raddr_a = (in_sort && !sel_b_ff) ? sort_raddr : ia_ff[IDX_W-1:0];
   assign raddr_b = (in_sort && sel_b_ff) ? sort_raddr : ib_ff[IDX_W-1:0];

   ssi_store #(.SET_DEPTH(SET_DEPTH)) u_store_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr_a),
      .wdata (wdata_a),
      .raddr (raddr_a),
      .rdata (rdata_a)
   );

   ssi_store #(.SET_DEPTH(SET_DEPTH)) u_store_b (
      .clock (clock),
      .we    (we_b),
      .waddr (waddr_b),
      .wdata (wdata_b),
      .raddr (raddr_b),
      .rdata (rdata_b)
   );

   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      drop_in      = drop_ff;
      sel_b_in     = sel_b_ff;
      lim_in       = lim_ff;
      j_in         = j_ff;
      hold_in      = hold_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      load_we_a    = 1'b0;
      load_we_b    = 1'b0;
      sort_we      = 1'b0;
      sort_waddr   = '0;
      sort_wdata   = hold_ff;
      sort_raddr   = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  ACT_LOAD_A: begin
                     if (count_a_ff < CNT_W'(SET_DEPTH)) begin
                        load_we_a  = 1'b1;
                        count_a_in = count_a_ff + 1'b1;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  ACT_LOAD_B: begin
                     if (count_b_ff < CNT_W'(SET_DEPTH)) begin
                        load_we_b  = 1'b1;
                        count_b_in = count_b_ff + 1'b1;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  ACT_RUN: begin
                     sel_b_in     = 1'b0;
                     ia_in        = '0;
                     ib_in        = '0;
                     have_pend_in = 1'b0;
                     state_in     = ST_SRT_START;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SRT_START: begin
            if (sort_n >= CNT_W'(2)) begin
               lim_in   = IDX_W'(sort_n - 1'b1);
               state_in = ST_SRT_RD0;
            end else if (!sel_b_ff) begin
               sel_b_in = 1'b1;
            end else begin
               state_in = ST_MRG_RD;
            end
         end
         ST_SRT_RD0: begin
            sort_raddr = '0;
            state_in   = ST_SRT_LD;
         end
         ST_SRT_LD: begin
            hold_in    = rdata_sel;
            sort_raddr = IDX_W'(1);
            j_in       = IDX_W'(1);
            state_in   = ST_SRT_SCAN;
         end
         ST_SRT_SCAN: begin
            // larger of the pair travels on in hold
            sort_we    = 1'b1;
            sort_waddr = j_ff - 1'b1;
            sort_wdata = cmp_gt ? rdata_sel : hold_ff;
            hold_in    = cmp_gt ? hold_ff : rdata_sel;
            if (j_ff == lim_ff) begin
               state_in = ST_SRT_LAST;
            end else begin
               sort_raddr = j_ff + 1'b1;
               j_in       = j_ff + 1'b1;
            end
         end
         ST_SRT_LAST: begin
            sort_we    = 1'b1;
            sort_waddr = lim_ff;
            sort_wdata = hold_ff;
            if (lim_ff == IDX_W'(1)) begin
               if (!sel_b_ff) begin
                  sel_b_in = 1'b1;
                  state_in = ST_SRT_START;
               end else begin
                  state_in = ST_MRG_RD;
               end
            end else begin
               lim_in   = lim_ff - 1'b1;
               state_in = ST_SRT_RD0;
            end
         end
         ST_MRG_RD: begin
            if ((ia_ff < count_a_ff) && (ib_ff < count_b_ff)) begin
               state_in = ST_MRG_CMP;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_MRG_CMP: begin
            if (cmp_gt) begin
               ib_in    = ib_ff + 1'b1;
               state_in = ST_MRG_RD;
            end else if (!cmp_eq) begin
               ia_in    = ia_ff + 1'b1;
               state_in = ST_MRG_RD;
            end else if (have_pend_ff && (rdata_a == pend_ff)) begin
               ia_in    = ia_ff + 1'b1;
               ib_in    = ib_ff + 1'b1;
               state_in = ST_MRG_RD;
            end else if (!have_pend_ff) begin
               pend_in      = rdata_a;
               have_pend_in = 1'b1;
               ia_in        = ia_ff + 1'b1;
               ib_in        = ib_ff + 1'b1;
               state_in     = ST_MRG_RD;
            end else if (out_free) begin
               // a newer match shows the pending one is not last
               rsp_valid_in = 1'b1;
               rsp_value_in = pend_ff;
               rsp_last_in  = 1'b0;
               rsp_empty_in = 1'b0;
               rsp_ovf_in   = drop_ff;
               pend_in      = rdata_a;
               ia_in        = ia_ff + 1'b1;
               ib_in        = ib_ff + 1'b1;
               state_in     = ST_MRG_RD;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = have_pend_ff ? pend_ff : '0;
               rsp_last_in  = 1'b1;
               rsp_empty_in = !have_pend_ff;
               rsp_ovf_in   = drop_ff;
               count_a_in   = '0;
               count_b_in   = '0;
               drop_in      = 1'b0;
               have_pend_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         drop_ff      <= 1'b0;
         sel_b_ff     <= 1'b0;
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         drop_ff      <= drop_in;
         sel_b_ff     <= sel_b_in;
         have_pend_ff <= have_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lim_ff       <= lim_in;
      j_ff         <= j_in;
      hold_ff      <= hold_in;
      ia_ff        <= ia_in;
      ib_ff        <= ib_in;
      pend_ff      <= pend_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_common_value = rsp_value_ff;
   assign rsp_is_last      = rsp_last_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_a_ff <= CNT_W'(SET_DEPTH)) && (count_b_ff <= CNT_W'(SET_DEPTH)))
      else $error("set count beyond depth");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_last_ff)
      else $error("empty result not marked last");

   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) && out_free |=>
         (count_a_ff == '0) && (count_b_ff == '0) && !drop_ff && (state_ff == ST_IDLE))
      else $error("run end did not clear sets");

   a_merge_bounds: assert property (@(posedge clock) disable iff (reset)
      in_merge |-> (ia_ff <= count_a_ff) && (ib_ff <= count_b_ff))
      else $error("merge index past set count");
`endif

endmodule

// ===== verif/sorted_set_intersection_checker.sv =====
`timescale 1ns / 1ps
module sorted_set_intersection_checker
   import ssi_pkg::*;
#(
   parameter int SET_DEPTH = SET_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [ACTION_W-1:0]      req_action,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [DATA_W-1:0] rsp_common_value,
   input  logic                     rsp_is_last,
   input  logic                     rsp_is_empty,
   input  logic                     rsp_overflowed,
   output int                       fail_count,
   output int                       pending,
   output int                       results_seen
);

   typedef logic signed [DATA_W-1:0] elem_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] common_value;
      logic                     is_last;
      logic                     is_empty;
      logic                     overflowed;
   } common_result_type;

   // both sets kept in ascending signed order as they load
   elem_type          sorted_sets [2][SET_DEPTH];
   int                fill [2];
   logic              dropped;
   common_result_type common_expected [$];
   common_result_type got_front;

   initial begin
      fail_count   = 0;
      pending      = 0;
      results_seen = 0;
      fill[0]      = 0;
      fill[1]      = 0;
      dropped      = 1'b0;
   end

   function automatic void load_elem(int sel, elem_type v);
      int j;
      if (fill[sel] < SET_DEPTH) begin
         j = fill[sel];
         while (j > 0 && sorted_sets[sel][j-1] > v) begin
            sorted_sets[sel][j] = sorted_sets[sel][j-1];
            j--;
         end
         sorted_sets[sel][j] = v;
         fill[sel]++;
      end else begin
         dropped = 1'b1;
      end
   endfunction

   function automatic void emit_common_values();
      int                ia;
      int                ib;
      int                found;
      common_result_type held;
      ia    = 0;
      ib    = 0;
      found = 0;
      held  = '0;
      while (ia < fill[0] && ib < fill[1]) begin
         if (sorted_sets[0][ia] > sorted_sets[1][ib]) begin
            ib++;
         end else if (sorted_sets[0][ia] < sorted_sets[1][ib]) begin
            ia++;
         end else begin
            if (found == 0 || sorted_sets[0][ia] != held.common_value) begin
               if (found != 0)
                  common_expected.push_back(held);
               held.common_value = sorted_sets[0][ia];
               held.is_last      = 1'b0;
               held.is_empty     = 1'b0;
               held.overflowed   = dropped;
               found++;
            end
            ia++;
            ib++;
         end
      end
      if (found == 0) begin
         held.common_value = '0;
         held.is_last      = 1'b1;
         held.is_empty     = 1'b1;
         held.overflowed   = dropped;
      end else begin
         held.is_last = 1'b1;
      end
      common_expected.push_back(held);
      fill[0] = 0;
      fill[1] = 0;
      dropped = 1'b0;
   endfunction

   task automatic check_field(string field, logic signed [DATA_W-1:0] exp_v,
                              logic signed [DATA_W-1:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill[0] = 0;
         fill[1] = 0;
         dropped = 1'b0;
         common_expected.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (common_expected.size() == 0) begin
               $display("%0t: unexpected result transaction, actual value %0d",
                        $time, rsp_common_value,
                        " last %0b empty %0b overflowed %0b",
                        rsp_is_last, rsp_is_empty, rsp_overflowed);
               fail_count++;
            end else begin
               got_front = common_expected.pop_front();
               check_field("common_value", got_front.common_value, rsp_common_value);
               check_field("is_last", got_front.is_last, rsp_is_last);
               check_field("is_empty", got_front.is_empty, rsp_is_empty);
               check_field("overflowed", got_front.overflowed, rsp_overflowed);
            end
         end
         if (req_valid && req_ready) begin
            case (req_action)
               ACT_LOAD_A: load_elem(0, req_value);
               ACT_LOAD_B: load_elem(1, req_value);
               ACT_RUN:    emit_common_values();
               default:    ;
            endcase
         end
      end
      pending = common_expected.size();
   end

endmodule

// ===== verif/sorted_set_intersection_unit_tb.sv =====
`timescale 1ns / 1ps
module sorted_set_intersection_unit_tb;
   import ssi_pkg::*;

   localparam int         SET_DEPTH = SET_DEPTH_DEF;
   localparam action_type ACT_NONE  = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   action_type               req_action;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_common_value;
   logic                     rsp_is_last;
   logic                     rsp_is_empty;
   logic                     rsp_overflowed;

   int fail_count;
   int pending;
   int results_seen;
   int loaded;
   bit calm;
   bit lively;

   always #5 clock = ~clock;

   sorted_set_intersection_unit #(.SET_DEPTH(SET_DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_common_value (rsp_common_value),
      .rsp_is_last      (rsp_is_last),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_overflowed   (rsp_overflowed)
   );

   sorted_set_intersection_checker #(.SET_DEPTH(SET_DEPTH)) result_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_common_value (rsp_common_value),
      .rsp_is_last      (rsp_is_last),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_overflowed   (rsp_overflowed),
      .fail_count       (fail_count),
      .pending          (pending),
      .results_seen     (results_seen)
   );

   function automatic data_type pick_value();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0:       return 32'h8000_0000;
               1:       return 32'h7fff_ffff;
               2:       return '1;
               default: return '0;
            endcase
         end
         default: return $urandom_range(0, 24) - 12;
      endcase
   endfunction

   function automatic int size_small();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
   endfunction

   task automatic send(action_type act, logic signed [DATA_W-1:0] v);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= v;
      if (act != ACT_NONE)
         loaded++;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic gap(int n);
      @(negedge clock);
      req_valid  <= 1'b0;
      req_action <= action_type'($urandom);
      req_value  <= $urandom;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic pace();
      if (!calm && lively && $urandom_range(0, 2) == 0)
         gap($urandom_range(1, 15));
   endtask

   // hold off until every outstanding result transaction has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic run_sequence(int na, int nb, bit spread);
      int                       la;
      int                       lb;
      bit                       pick_a;
      logic signed [DATA_W-1:0] v;
      lively = ($urandom_range(0, 2) != 0);
      la     = 0;
      lb     = 0;
      while (la < na || lb < nb) begin
         pace();
         if ($urandom_range(0, 19) == 0) begin
            send(ACT_NONE, $urandom);
         end else begin
            pick_a = (lb >= nb) || (la < na && $urandom_range(0, 1) == 1);
            if (pick_a) begin
               v = spread ? ((la * 11) % SET_DEPTH) * 3 - 40 : pick_value();
               send(ACT_LOAD_A, v);
               la++;
            end else begin
               v = spread ? ((lb * 5) % SET_DEPTH) * 3 - 40 : pick_value();
               send(ACT_LOAD_B, v);
               lb++;
            end
         end
      end
      pace();
      send(ACT_RUN, $urandom);
      if (!calm && $urandom_range(0, 3) == 0)
         drain();
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30) - 1) @(negedge clock);
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_action = ACT_LOAD_A;
      req_value  = '0;
      loaded     = 0;
      calm       = 1'b0;
      lively     = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // both sets empty
      send(ACT_RUN, 32'h1234_5678);
      send(ACT_NONE, 32'hffff_ffff);
      // extremes in both sets
      send(ACT_LOAD_A, 32'h8000_0000);
      send(ACT_LOAD_A, 32'h7fff_ffff);
      send(ACT_LOAD_B, 32'h7fff_ffff);
      send(ACT_LOAD_B, 32'h0000_0000);
      send(ACT_LOAD_B, 32'h8000_0000);
      send(ACT_RUN, 32'h0);
      // duplicates within and across sets
      send(ACT_LOAD_A, 5);
      send(ACT_LOAD_A, 5);
      send(ACT_LOAD_A, 5);
      send(ACT_LOAD_B, 5);
      send(ACT_LOAD_B, 5);
      send(ACT_LOAD_B, -5);
      send(ACT_RUN, 32'hdead_beef);
      // one set empty
      send(ACT_LOAD_A, 7);
      send(ACT_RUN, 32'h0);
      // disjoint sets
      send(ACT_LOAD_A, 1);
      send(ACT_LOAD_B, 2);
      send(ACT_RUN, 32'h5555_aaaa);
      drain();

      // both sets full, set A overflows
      run_sequence(SET_DEPTH + 2, SET_DEPTH, 1'b1);

      while (loaded < 100) begin
         if ($urandom_range(0, 15) == 0)
            run_sequence(SET_DEPTH + $urandom_range(0, 2),
                         $urandom_range(SET_DEPTH / 2, SET_DEPTH + 1), 1'b1);
         else
            run_sequence(size_small(), size_small(), 1'b0);
      end

      calm = 1'b1;
      repeat (3) run_sequence(size_small(), size_small(), 1'b0);
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/ssi_pkg.sv
design/ssi_store.sv
design/sorted_set_intersection_unit.sv
verif/sorted_set_intersection_checker.sv
verif/sorted_set_intersection_unit_tb.sv
